### hdl/apf_pkg.sv
// Shared constants, types and the sequencer state encoding for the
// articulation point finder. No dependencies.
package apf_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 256;
    localparam int HALF_EDGES   = 2 * MAX_EDGES;

    localparam int VID_W   = 6;
    localparam int CNT_W   = 7;
    localparam int TIME_W  = $clog2(MAX_VERTICES + 1);
    localparam int LINK_W  = $clog2(HALF_EDGES + 1);
    localparam int EADDR_W = $clog2(HALF_EDGES);
    localparam int STK_AW  = $clog2(MAX_VERTICES);
    localparam int EDGE_W  = VID_W + LINK_W;

    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(HALF_EDGES);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_A,
        S_ADD_B,
        S_ADD_C,
        S_SCAN,
        S_HEAD,
        S_EDGE,
        S_EDGE_D,
        S_BACK,
        S_POP1,
        S_POP2,
        S_EMIT
    } t_state;

    // One suspended level of the depth-first walk.
    typedef struct packed {
        logic [VID_W-1:0]  vertex;
        logic [LINK_W-1:0] link;
        logic [VID_W-1:0]  parent;
        logic              has_parent;
    } t_frame;

endpackage

### hdl/apf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module apf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### hdl/articulation_point_finder_unit.sv
// Top level of the articulation point finder: edge store, walk sequencer
// and result output register. Depends on apf_pkg and apf_ram.
//
// Usage: input items arrive on i_in_valid / o_in_ready. An item with
// i_op low adds the undirected edge (i_end_a, i_end_b); a bad edge (endpoint
// out of range or a self-loop) is dropped, and an edge that does not fit in
// the edge store is dropped and sets the sticky edges_lost flag. An item
// with i_op high runs a depth-first cut-vertex search over the stored graph
// and then emits the cut vertices in descending id order on o_out_valid /
// i_out_ready, the last one with o_is_last set, or one "none found" item.
// A kept edge passes through the ADD_A, ADD_B and ADD_C states. The
// list-head, edge, stack and time memories each have one write port and
// one read port with registered read data.
// The block takes no new item until the current one is finished. A result
// sits in an output register, so a finished run leaves the block ready
// while its last item still waits; a stalled receiver holds the output scan.
// vertex_count is to be written through i_cfg_we / i_cfg_data only while
// idle; the block itself does not enforce it. Reset (synchronous, active
// low) empties the graph, clears edges_lost and sets vertex_count to 64;
// no clearing pass is needed.
module articulation_point_finder_unit
    import apf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_op,
    input  logic [VID_W-1:0] i_end_a,
    input  logic [VID_W-1:0] i_end_b,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [VID_W-1:0] o_vertex_id,
    output logic             o_found,
    output logic             o_is_last,
    output logic             o_edges_lost
);

    t_state r_state, n_state;
    logic [CNT_W-1:0]        r_vcount, n_vcount;
    logic [LINK_W-1:0]       r_used, n_used;
    logic                    r_ovf, n_ovf;
    logic [VID_W-1:0]        r_a, n_a, r_b, n_b;
    logic [MAX_VERTICES-1:0] r_seen, n_seen, r_cut, n_cut, r_lhv, n_lhv;
    logic [TIME_W-1:0]       r_time, n_time, r_lowu, n_lowu, r_clow, n_clow;
    logic [CNT_W-1:0]        r_depth, n_depth, r_idx, n_idx;
    logic [VID_W-1:0]        r_u, n_u, r_par, n_par;
    logic [LINK_W-1:0]       r_link, n_link;
    logic                    r_haspar, n_haspar;
    logic [1:0]              r_rootch, n_rootch;
    logic                    r_hvld;
    logic                    r_ovalid, n_ovalid;
    logic [VID_W-1:0]        r_ovid, n_ovid;
    logic                    r_ofound, n_ofound, r_olast, n_olast, r_olost, n_olost;

    // Memory ports.
    logic                  lh_we;
    logic [VID_W-1:0]      lh_waddr, lh_raddr;
    logic [LINK_W-1:0]     lh_wdata, lh_rdata;
    logic                  e_we;
    logic [EADDR_W-1:0]    e_waddr, e_raddr;
    logic [EDGE_W-1:0]     e_wdata, e_rdata;
    logic                  s_we;
    logic [STK_AW-1:0]     s_waddr, s_raddr;
    t_frame                s_wdata, s_rdata;
    logic                  d_we;
    logic [VID_W-1:0]      d_waddr, d_raddr;
    logic [TIME_W-1:0]     d_wdata, d_rdata;
    logic                  l_we;
    logic [VID_W-1:0]      l_waddr, l_raddr;
    logic [TIME_W-1:0]     l_wdata, l_rdata;

    logic [CNT_W-1:0]  cnt;
    logic [LINK_W-1:0] head;
    logic [VID_W-1:0]  e_target;
    logic [LINK_W-1:0] e_next;
    logic [CNT_W-1:0]  depth_m1, depth_m2, idx_m1;
    logic              can_load;

    assign cnt      = (r_vcount > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : r_vcount;
    assign head     = r_hvld ? lh_rdata : LINK_NULL;
    assign e_target = e_rdata[EDGE_W-1:LINK_W];
    assign e_next   = e_rdata[LINK_W-1:0];
    assign depth_m1 = r_depth - CNT_W'(1);
    assign depth_m2 = r_depth - CNT_W'(2);
    assign idx_m1   = r_idx - CNT_W'(1);
    assign can_load = !r_ovalid || i_out_ready;

    apf_ram #(.WIDTH(LINK_W), .DEPTH(MAX_VERTICES)) u_head_ram (
        .i_clk(i_clk), .i_we(lh_we), .i_waddr(lh_waddr), .i_wdata(lh_wdata),
        .i_raddr(lh_raddr), .o_rdata(lh_rdata)
    );

    apf_ram #(.WIDTH(EDGE_W), .DEPTH(HALF_EDGES)) u_edge_ram (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_waddr), .i_wdata(e_wdata),
        .i_raddr(e_raddr), .o_rdata(e_rdata)
    );

    apf_ram #(.WIDTH($bits(t_frame)), .DEPTH(MAX_VERTICES)) u_stack_ram (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );

    apf_ram #(.WIDTH(TIME_W), .DEPTH(MAX_VERTICES)) u_disc_ram (
        .i_clk(i_clk), .i_we(d_we), .i_waddr(d_waddr), .i_wdata(d_wdata),
        .i_raddr(d_raddr), .o_rdata(d_rdata)
    );

    apf_ram #(.WIDTH(TIME_W), .DEPTH(MAX_VERTICES)) u_low_ram (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(l_waddr), .i_wdata(l_wdata),
        .i_raddr(l_raddr), .o_rdata(l_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vcount <= CNT_W'(MAX_VERTICES);
            r_used   <= '0;
            r_ovf    <= 1'b0;
            r_seen   <= '0;
            r_cut    <= '0;
            r_lhv    <= '0;
            r_depth  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_vcount <= n_vcount;
            r_used   <= n_used;
            r_ovf    <= n_ovf;
            r_seen   <= n_seen;
            r_cut    <= n_cut;
            r_lhv    <= n_lhv;
            r_depth  <= n_depth;
            r_ovalid <= n_ovalid;
        end
        r_a      <= n_a;
        r_b      <= n_b;
        r_time   <= n_time;
        r_lowu   <= n_lowu;
        r_clow   <= n_clow;
        r_idx    <= n_idx;
        r_u      <= n_u;
        r_par    <= n_par;
        r_link   <= n_link;
        r_haspar <= n_haspar;
        r_rootch <= n_rootch;
        r_hvld   <= r_lhv[lh_raddr];
        r_ovid   <= n_ovid;
        r_ofound <= n_ofound;
        r_olast  <= n_olast;
        r_olost  <= n_olost;
    end

    always_comb begin
        logic             do_push;
        logic [VID_W-1:0] push_v;
        logic [VID_W-1:0] ev;
        logic [MAX_VERTICES-1:0] lower;

        n_state  = r_state;
        n_vcount = i_cfg_we ? i_cfg_data : r_vcount;
        n_used   = r_used;
        n_ovf    = r_ovf;
        n_a      = r_a;
        n_b      = r_b;
        n_seen   = r_seen;
        n_cut    = r_cut;
        n_lhv    = r_lhv;
        n_time   = r_time;
        n_lowu   = r_lowu;
        n_clow   = r_clow;
        n_depth  = r_depth;
        n_idx    = r_idx;
        n_u      = r_u;
        n_par    = r_par;
        n_link   = r_link;
        n_haspar = r_haspar;
        n_rootch = r_rootch;
        n_ovalid = r_ovalid && !i_out_ready;
        n_ovid   = r_ovid;
        n_ofound = r_ofound;
        n_olast  = r_olast;
        n_olost  = r_olost;

        lh_we    = 1'b0;
        lh_waddr = r_a;
        lh_wdata = r_used;
        lh_raddr = r_a;
        e_we     = 1'b0;
        e_waddr  = r_used[EADDR_W-1:0];
        e_wdata  = {r_b, head};
        e_raddr  = r_link[EADDR_W-1:0];
        s_we     = 1'b0;
        s_waddr  = depth_m1[STK_AW-1:0];
        s_wdata  = '{vertex: r_u, link: e_next, parent: r_par, has_parent: r_haspar};
        s_raddr  = depth_m2[STK_AW-1:0];
        d_we     = 1'b0;
        d_waddr  = r_u;
        d_wdata  = r_time + TIME_W'(1);
        d_raddr  = e_target;
        l_we     = 1'b0;
        l_waddr  = r_u;
        l_wdata  = r_lowu;
        l_raddr  = s_rdata.vertex;

        do_push = 1'b0;
        push_v  = r_idx[VID_W-1:0];
        ev      = idx_m1[VID_W-1:0];
        lower   = r_cut & ((MAX_VERTICES'(1) << ev) - MAX_VERTICES'(1));

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_a = i_end_a;
                    n_b = i_end_b;
                    if (i_op) begin
                        n_seen  = '0;
                        n_cut   = '0;
                        n_time  = '0;
                        n_depth = '0;
                        n_idx   = '0;
                        n_state = S_SCAN;
                    end else if (CNT_W'(i_end_a) >= cnt || CNT_W'(i_end_b) >= cnt
                                 || i_end_a == i_end_b) begin
                        n_state = S_IDLE;
                    end else if (r_used > LINK_W'(HALF_EDGES - 2)) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_state = S_ADD_A;
                    end
                end
            end
            S_ADD_A: begin
                n_state = S_ADD_B;
            end
            S_ADD_B: begin
                // Head of end_a is ready; link the first half-edge in front.
                e_we     = 1'b1;
                lh_we    = 1'b1;
                n_lhv[r_a] = 1'b1;
                lh_raddr = r_b;
                n_used   = r_used + LINK_W'(1);
                n_state  = S_ADD_C;
            end
            S_ADD_C: begin
                e_we     = 1'b1;
                e_wdata  = {r_a, head};
                lh_we    = 1'b1;
                lh_waddr = r_b;
                n_lhv[r_b] = 1'b1;
                n_used   = r_used + LINK_W'(1);
                n_state  = S_IDLE;
            end
            S_SCAN: begin
                if (r_idx >= cnt) begin
                    n_idx   = cnt;
                    n_state = S_EMIT;
                end else if (r_seen[r_idx[VID_W-1:0]]) begin
                    n_idx = r_idx + CNT_W'(1);
                end else begin
                    do_push  = 1'b1;
                    push_v   = r_idx[VID_W-1:0];
                    n_haspar = 1'b0;
                    n_par    = '0;
                    n_rootch = '0;
                end
            end
            S_HEAD: begin
                n_link  = head;
                n_state = S_EDGE;
            end
            S_EDGE: begin
                if (r_link == LINK_NULL) begin
                    n_depth = depth_m1;
                    n_clow  = r_lowu;
                    if (r_depth == CNT_W'(1)) begin
                        n_idx   = r_idx + CNT_W'(1);
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_POP1;
                    end
                end else begin
                    n_state = S_EDGE_D;
                end
            end
            S_EDGE_D: begin
                n_link  = e_next;
                n_state = S_EDGE;
                if (CNT_W'(e_target) >= cnt) begin
                    n_state = S_EDGE;
                end else if (!r_seen[e_target]) begin
                    // Tree edge: suspend the current vertex on the stack.
                    s_we     = 1'b1;
                    l_we     = 1'b1;
                    do_push  = 1'b1;
                    push_v   = e_target;
                    n_par    = r_u;
                    n_haspar = 1'b1;
                    if (r_depth == CNT_W'(1) && r_rootch != 2'd2) begin
                        n_rootch = r_rootch + 2'd1;
                    end
                end else if (!(r_haspar && e_target == r_par)) begin
                    n_state = S_BACK;
                end
            end
            S_BACK: begin
                if (d_rdata < r_lowu) begin
                    n_lowu = d_rdata;
                end
                n_state = S_EDGE;
            end
            S_POP1: begin
                n_u      = s_rdata.vertex;
                n_link   = s_rdata.link;
                n_par    = s_rdata.parent;
                n_haspar = s_rdata.has_parent;
                d_raddr  = s_rdata.vertex;
                n_state  = S_POP2;
            end
            S_POP2: begin
                n_lowu = (r_clow < l_rdata) ? r_clow : l_rdata;
                if (!r_haspar) begin
                    if (r_rootch == 2'd2) begin
                        n_cut[r_u] = 1'b1;
                    end
                end else if (r_clow >= d_rdata) begin
                    n_cut[r_u] = 1'b1;
                end
                n_state = S_EDGE;
            end
            S_EMIT: begin
                if (r_cut == '0) begin
                    if (can_load) begin
                        n_ovalid = 1'b1;
                        n_ovid   = '0;
                        n_ofound = 1'b0;
                        n_olast  = 1'b1;
                        n_olost  = r_ovf;
                        n_state  = S_IDLE;
                    end
                end else if (r_idx == '0) begin
                    n_state = S_IDLE;
                end else if (r_cut[ev]) begin
                    if (can_load) begin
                        n_ovalid = 1'b1;
                        n_ovid   = ev;
                        n_ofound = 1'b1;
                        n_olast  = (lower == '0);
                        n_olost  = r_ovf;
                        n_idx    = idx_m1;
                    end
                end else begin
                    n_idx = idx_m1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_push) begin
            n_seen[push_v] = 1'b1;
            n_time   = r_time + TIME_W'(1);
            n_lowu   = r_time + TIME_W'(1);
            d_we     = 1'b1;
            d_waddr  = push_v;
            n_u      = push_v;
            n_depth  = r_depth + CNT_W'(1);
            lh_raddr = push_v;
            n_state  = S_HEAD;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_ovalid;
    assign o_vertex_id  = r_ovid;
    assign o_found      = r_ofound;
    assign o_is_last    = r_olast;
    assign o_edges_lost = r_olost;

    // The walk stack is empty whenever a new item can be taken.
    a_idle_stack_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_depth == '0))
        else $error("walk stack not empty while idle");

    // Half-edges are always stored in pairs and never beyond the store.
    a_used_pairs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used[0] == 1'b0 || r_state == S_ADD_C) && r_used <= LINK_W'(HALF_EDGES))
        else $error("half-edge count out of step");

    // The walk never goes deeper than MAX_VERTICES.
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= CNT_W'(MAX_VERTICES))
        else $error("walk stack overflow");

    // The overflow flag is sticky.
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |=> r_ovf)
        else $error("edges_lost flag cleared");

    // A none-found item is always the last item of its run.
    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> o_is_last)
        else $error("none-found item not marked last");

endmodule
